>>> hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DOB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DOB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/dob_pkg.sv
`timescale 1ns / 1ps

package dob_pkg;

   localparam int MAX_POINTS_DEF = 32;
   localparam int IDX_W          = 6;
   localparam int CNT_W          = 7;
   localparam int SIZE_W         = 32;
   localparam int VAL_W          = 32;
   localparam int EPS_W          = 16;
   localparam int R_W            = 50;
   localparam int VMR_W          = 52;
   localparam int DIFF_W         = 33;
   localparam int PROD_W         = 66;
   localparam int CMP_W          = 88;

   typedef struct packed {
      logic [IDX_W-1:0]         idx;
      logic [SIZE_W-1:0]        size;
      logic signed [VAL_W-1:0]  value;
   } point_type;

   localparam int POINT_W = IDX_W + SIZE_W + VAL_W;

   typedef enum logic [1:0] {
      SL_ABSENT,
      SL_INF,
      SL_QUAL,
      SL_FAIL
   } slope_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_HULL_INIT,
      ST_HULL_RD,
      ST_HULL_LD,
      ST_HULL_CHK,
      ST_MUL1,
      ST_MUL2,
      ST_HULL_CMP,
      ST_POP,
      ST_POP_LD,
      ST_PUSH,
      ST_EMIT_RD0,
      ST_EMIT_LD0,
      ST_EMIT_NXT,
      ST_NEXT_RD,
      ST_NEXT_LD,
      ST_VMR,
      ST_TM1,
      ST_TM2,
      ST_TM3,
      ST_TRES,
      ST_DEC,
      ST_SHIFT,
      ST_FIN
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCAN_CMP,
      OP_HULL_INIT,
      OP_HULL_LD,
      OP_MUL1,
      OP_MUL2,
      OP_POP,
      OP_POP_LD,
      OP_PUSH,
      OP_EMIT_RD0,
      OP_EMIT_LD0,
      OP_NEXT_RD,
      OP_NEXT_LD,
      OP_VMR,
      OP_TM1,
      OP_TM2,
      OP_TM3,
      OP_TRES,
      OP_DEC,
      OP_SHIFT,
      OP_FIN
   } op_type;

   typedef struct packed {
      op_type op;
      logic   side;
   } cmd_type;

   typedef struct packed {
      logic k_last_pt;
      logic j_last;
      logic have_prev;
      logic depth_ge2;
      logic turn_right;
      logic qualify;
      logic pend_vld;
      logic slot_free;
   } stat_type;

   // unsigned sizes to a signed difference
   function automatic logic signed [DIFF_W-1:0] size_diff(input logic [SIZE_W-1:0] x,
                                                          input logic [SIZE_W-1:0] y);
      size_diff = $signed({1'b0, x}) - $signed({1'b0, y});
   endfunction

   function automatic logic signed [DIFF_W-1:0] value_diff(input logic signed [VAL_W-1:0] x,
                                                           input logic signed [VAL_W-1:0] y);
      value_diff = $signed({x[VAL_W-1], x}) - $signed({y[VAL_W-1], y});
   endfunction

endpackage

>>> hdl/dob_ram.sv
`timescale 1ns / 1ps

module dob_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/dob_ctrl.sv
`timescale 1ns / 1ps

module dob_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_final_point,
   output logic               req_ready,
   input  dob_pkg::stat_type  stat,
   output dob_pkg::cmd_type   cmd
);

   dob_pkg::state_type state_ff, state_in;
   logic side_ff, side_in;
   logic dec_go;

   // a new qualifier only waits when it pushes out an older one
   assign dec_go = !(stat.qualify && stat.pend_vld) || stat.slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dob_pkg::ST_IDLE;
         side_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      case (state_ff)
         dob_pkg::ST_IDLE: begin
            if (req_valid && req_final_point) state_in = dob_pkg::ST_SCAN_RD;
         end
         dob_pkg::ST_SCAN_RD:   state_in = dob_pkg::ST_SCAN_CMP;
         dob_pkg::ST_SCAN_CMP: begin
            state_in = stat.k_last_pt ? dob_pkg::ST_HULL_INIT : dob_pkg::ST_SCAN_RD;
         end
         dob_pkg::ST_HULL_INIT: state_in = dob_pkg::ST_HULL_RD;
         dob_pkg::ST_HULL_RD:   state_in = dob_pkg::ST_HULL_LD;
         dob_pkg::ST_HULL_LD:   state_in = dob_pkg::ST_HULL_CHK;
         dob_pkg::ST_HULL_CHK: begin
            state_in = stat.depth_ge2 ? dob_pkg::ST_MUL1 : dob_pkg::ST_PUSH;
         end
         dob_pkg::ST_MUL1:      state_in = dob_pkg::ST_MUL2;
         dob_pkg::ST_MUL2:      state_in = dob_pkg::ST_HULL_CMP;
         dob_pkg::ST_HULL_CMP: begin
            state_in = stat.turn_right ? dob_pkg::ST_POP : dob_pkg::ST_PUSH;
         end
         dob_pkg::ST_POP:       state_in = dob_pkg::ST_POP_LD;
         dob_pkg::ST_POP_LD:    state_in = dob_pkg::ST_HULL_CHK;
         dob_pkg::ST_PUSH: begin
            state_in = stat.k_last_pt ? dob_pkg::ST_EMIT_RD0 : dob_pkg::ST_HULL_RD;
         end
         dob_pkg::ST_EMIT_RD0:  state_in = dob_pkg::ST_EMIT_LD0;
         dob_pkg::ST_EMIT_LD0:  state_in = dob_pkg::ST_EMIT_NXT;
         dob_pkg::ST_EMIT_NXT: begin
            state_in = stat.j_last ? dob_pkg::ST_VMR : dob_pkg::ST_NEXT_RD;
         end
         dob_pkg::ST_NEXT_RD:   state_in = dob_pkg::ST_NEXT_LD;
         dob_pkg::ST_NEXT_LD:   state_in = dob_pkg::ST_VMR;
         dob_pkg::ST_VMR: begin
            if (stat.have_prev) begin
               state_in = dob_pkg::ST_TM1;
               side_in  = 1'b0;
            end else if (!stat.j_last) begin
               state_in = dob_pkg::ST_TM1;
               side_in  = 1'b1;
            end else begin
               state_in = dob_pkg::ST_DEC;
            end
         end
         dob_pkg::ST_TM1:       state_in = dob_pkg::ST_TM2;
         dob_pkg::ST_TM2:       state_in = dob_pkg::ST_TM3;
         dob_pkg::ST_TM3:       state_in = dob_pkg::ST_TRES;
         dob_pkg::ST_TRES: begin
            if (!side_ff && !stat.j_last) begin
               state_in = dob_pkg::ST_TM1;
               side_in  = 1'b1;
            end else begin
               state_in = dob_pkg::ST_DEC;
            end
         end
         dob_pkg::ST_DEC: begin
            if (dec_go) state_in = stat.j_last ? dob_pkg::ST_FIN : dob_pkg::ST_SHIFT;
         end
         dob_pkg::ST_SHIFT:     state_in = dob_pkg::ST_EMIT_NXT;
         dob_pkg::ST_FIN: begin
            if (stat.slot_free) state_in = dob_pkg::ST_IDLE;
         end
         default:               state_in = dob_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.side  = side_ff;
      cmd.op    = dob_pkg::OP_NONE;
      case (state_ff)
         dob_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = dob_pkg::OP_LOAD;
         end
         dob_pkg::ST_SCAN_CMP:  cmd.op = dob_pkg::OP_SCAN_CMP;
         dob_pkg::ST_HULL_INIT: cmd.op = dob_pkg::OP_HULL_INIT;
         dob_pkg::ST_HULL_LD:   cmd.op = dob_pkg::OP_HULL_LD;
         dob_pkg::ST_MUL1:      cmd.op = dob_pkg::OP_MUL1;
         dob_pkg::ST_MUL2:      cmd.op = dob_pkg::OP_MUL2;
         dob_pkg::ST_POP:       cmd.op = dob_pkg::OP_POP;
         dob_pkg::ST_POP_LD:    cmd.op = dob_pkg::OP_POP_LD;
         dob_pkg::ST_PUSH:      cmd.op = dob_pkg::OP_PUSH;
         dob_pkg::ST_EMIT_RD0:  cmd.op = dob_pkg::OP_EMIT_RD0;
         dob_pkg::ST_EMIT_LD0:  cmd.op = dob_pkg::OP_EMIT_LD0;
         dob_pkg::ST_NEXT_RD:   cmd.op = dob_pkg::OP_NEXT_RD;
         dob_pkg::ST_NEXT_LD:   cmd.op = dob_pkg::OP_NEXT_LD;
         dob_pkg::ST_VMR:       cmd.op = dob_pkg::OP_VMR;
         dob_pkg::ST_TM1:       cmd.op = dob_pkg::OP_TM1;
         dob_pkg::ST_TM2:       cmd.op = dob_pkg::OP_TM2;
         dob_pkg::ST_TM3:       cmd.op = dob_pkg::OP_TM3;
         dob_pkg::ST_TRES:      cmd.op = dob_pkg::OP_TRES;
         dob_pkg::ST_DEC: begin
            if (dec_go) cmd.op = dob_pkg::OP_DEC;
         end
         dob_pkg::ST_SHIFT:     cmd.op = dob_pkg::OP_SHIFT;
         dob_pkg::ST_FIN: begin
            if (stat.slot_free) cmd.op = dob_pkg::OP_FIN;
         end
         default:               cmd.op = dob_pkg::OP_NONE;
      endcase
   end

endmodule

>>> hdl/dob_datapath.sv
`timescale 1ns / 1ps

module dob_datapath #(
   parameter int MAX_POINTS = dob_pkg::MAX_POINTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dob_pkg::cmd_type                 cmd,
   output dob_pkg::stat_type                stat,
   input  logic [dob_pkg::SIZE_W-1:0]       req_box_size,
   input  logic signed [dob_pkg::VAL_W-1:0] req_box_value,
   input  logic signed [dob_pkg::VAL_W-1:0] req_best_value,
   input  logic                             csr_wr_en,
   input  logic [dob_pkg::EPS_W-1:0]        csr_wr_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [dob_pkg::IDX_W-1:0]        rsp_point_index,
   output logic [dob_pkg::SIZE_W-1:0]       rsp_sel_size,
   output logic signed [dob_pkg::VAL_W-1:0] rsp_sel_value,
   output logic                             rsp_by_fallback,
   output logic                             rsp_end_of_run
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CW    = dob_pkg::CNT_W;
   localparam int DW    = dob_pkg::DIFF_W;
   localparam int PW    = dob_pkg::PROD_W;
   localparam int VW    = dob_pkg::VAL_W;
   localparam int SW    = dob_pkg::SIZE_W;
   localparam int MW    = dob_pkg::VMR_W;
   localparam int RW    = dob_pkg::R_W;
   localparam int QW    = dob_pkg::CMP_W;
   localparam int HIW   = MW - 32;
   localparam int HPW   = HIW + DW;

   // control registers
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic          pend_vld_ff, pend_vld_in;
   logic          out_vld_ff, out_vld_in;
   logic [dob_pkg::EPS_W-1:0] eps_ff, eps_in;

   // payload registers
   logic [CW-1:0]            k_ff, k_in;
   logic [CW-1:0]            start_ff, start_in;
   logic signed [VW-1:0]     minv_ff, minv_in;
   logic signed [RW-1:0]     r_ff, r_in;
   dob_pkg::point_type       a_ff, a_in, b_ff, b_in, c_ff, c_in;
   dob_pkg::point_type       prev_ff, prev_in, cur_ff, cur_in, next_ff, next_in;
   dob_pkg::point_type       pend_ff, pend_in;
   logic signed [PW-1:0]     prod1_ff, prod1_in, prod2_ff, prod2_in;
   logic signed [PW-1:0]     tp_ff, tp_in, tql_ff, tql_in, tqh_ff, tqh_in;
   logic signed [MW-1:0]     vmr_ff, vmr_in;
   dob_pkg::slope_type       t1_ff, t1_in, t2_ff, t2_in;
   dob_pkg::point_type       out_ff, out_in;
   logic                     out_fb_ff, out_fb_in, out_end_ff, out_end_in;

   // memories
   logic [SW-1:0]            size_rd;
   logic [VW-1:0]            value_rd;
   logic [dob_pkg::POINT_W-1:0] hull_rd;
   dob_pkg::point_type       hull_pt;
   logic [AW-1:0]            hull_rd_addr;
   logic                     room;
   logic                     pt_wr;

   // arithmetic
   logic signed [DW-1:0]     mul_a, mul_b;
   logic signed [PW-1:0]     mul_p;
   dob_pkg::point_type       p_pt, q_pt;
   logic signed [DW-1:0]     dd, dz;
   logic signed [DW-1:0]     best_abs;
   logic signed [RW-1:0]     eps_prod;
   logic signed [QW-1:0]     p_w, q_w;
   logic                     cmp_ok;
   dob_pkg::slope_type       code;
   logic                     slot_free;

   assign room  = cnt_ff < CW'(MAX_POINTS);
   assign pt_wr = (cmd.op == dob_pkg::OP_LOAD) && room;

   dob_ram #(.WIDTH(SW), .DEPTH(MAX_POINTS)) u_size_ram (
      .clock   (clock),
      .wr_en   (pt_wr),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (req_box_size),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (size_rd)
   );

   dob_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_value_ram (
      .clock   (clock),
      .wr_en   (pt_wr),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (req_box_value),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (value_rd)
   );

   dob_ram #(.WIDTH(dob_pkg::POINT_W), .DEPTH(MAX_POINTS)) u_hull_ram (
      .clock   (clock),
      .wr_en   (cmd.op == dob_pkg::OP_PUSH),
      .wr_addr (depth_ff[AW-1:0]),
      .wr_data (c_ff),
      .rd_addr (hull_rd_addr),
      .rd_data (hull_rd)
   );

   assign hull_pt = hull_rd;

   always_comb begin
      case (cmd.op)
         dob_pkg::OP_POP:      hull_rd_addr = AW'(depth_ff - CW'(3));
         dob_pkg::OP_NEXT_RD:  hull_rd_addr = AW'(k_ff + CW'(1));
         default:              hull_rd_addr = '0;
      endcase
   end

   // threshold best - eps*|best| in q.16 units
   assign best_abs = req_best_value[VW-1] ? -$signed({req_best_value[VW-1], req_best_value})
                                          :  $signed({req_best_value[VW-1], req_best_value});
   assign eps_prod = $signed({1'b0, eps_ff}) * best_abs;

   // slope operands: left test is prev->cur, right test is cur->next
   assign p_pt = cmd.side ? cur_ff  : prev_ff;
   assign q_pt = cmd.side ? next_ff : cur_ff;
   assign dd   = dob_pkg::size_diff(q_pt.size, p_pt.size);
   assign dz   = dob_pkg::value_diff(q_pt.value, p_pt.value);

   // one shared multiplier
   always_comb begin
      case (cmd.op)
         dob_pkg::OP_MUL1: begin
            mul_a = dob_pkg::size_diff(a_ff.size, c_ff.size);
            mul_b = dob_pkg::value_diff(b_ff.value, c_ff.value);
         end
         dob_pkg::OP_MUL2: begin
            mul_a = dob_pkg::value_diff(a_ff.value, c_ff.value);
            mul_b = dob_pkg::size_diff(b_ff.size, c_ff.size);
         end
         dob_pkg::OP_TM1: begin
            mul_a = dz;
            mul_b = $signed({1'b0, cur_ff.size});
         end
         dob_pkg::OP_TM2: begin
            mul_a = $signed({1'b0, vmr_ff[31:0]});
            mul_b = dd;
         end
         dob_pkg::OP_TM3: begin
            mul_a = $signed({{(DW-HIW){vmr_ff[MW-1]}}, vmr_ff[MW-1:32]});
            mul_b = dd;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // dz*s*2^16 against vmr*dd
   assign p_w = $signed({{(QW-PW-16){tp_ff[PW-1]}}, tp_ff, 16'b0});
   assign q_w = $signed({{(QW-HPW-32){tqh_ff[HPW-1]}}, tqh_ff[HPW-1:0], 32'b0})
              + $signed({{(QW-PW){tql_ff[PW-1]}}, tql_ff});
   assign cmp_ok = dd[DW-1] ? (p_w <= q_w) : (p_w >= q_w);

   always_comb begin
      if (dd == '0) begin
         code = (dz > 0) ? dob_pkg::SL_INF : dob_pkg::SL_ABSENT;
      end else if (cur_ff.size == '0) begin
         code = (vmr_ff[MW-1] || vmr_ff == '0) ? dob_pkg::SL_QUAL : dob_pkg::SL_FAIL;
      end else begin
         code = cmp_ok ? dob_pkg::SL_QUAL : dob_pkg::SL_FAIL;
      end
   end

   assign slot_free = !out_vld_ff || rsp_ready;

   always_comb begin
      cnt_in      = cnt_ff;
      depth_in    = depth_ff;
      pend_vld_in = pend_vld_ff;
      out_vld_in  = (out_vld_ff && !rsp_ready);
      eps_in      = csr_wr_en ? csr_wr_data : eps_ff;
      k_in        = k_ff;
      start_in    = start_ff;
      minv_in     = minv_ff;
      r_in        = r_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      c_in        = c_ff;
      prev_in     = prev_ff;
      cur_in      = cur_ff;
      next_in     = next_ff;
      pend_in     = pend_ff;
      prod1_in    = prod1_ff;
      prod2_in    = prod2_ff;
      tp_in       = tp_ff;
      tql_in      = tql_ff;
      tqh_in      = tqh_ff;
      vmr_in      = vmr_ff;
      t1_in       = t1_ff;
      t2_in       = t2_ff;
      out_in      = out_ff;
      out_fb_in   = out_fb_ff;
      out_end_in  = out_end_ff;
      case (cmd.op)
         dob_pkg::OP_LOAD: begin
            if (room) cnt_in = cnt_ff + CW'(1);
            k_in     = '0;
            start_in = '0;
            r_in     = $signed({{(RW-VW-16){req_best_value[VW-1]}}, req_best_value, 16'b0})
                     - eps_prod;
         end
         dob_pkg::OP_SCAN_CMP: begin
            if (k_ff == '0 || $signed(value_rd) < minv_ff) begin
               minv_in  = $signed(value_rd);
               start_in = k_ff;
            end
            k_in = k_ff + CW'(1);
         end
         dob_pkg::OP_HULL_INIT: begin
            k_in     = start_ff;
            depth_in = '0;
         end
         dob_pkg::OP_HULL_LD: begin
            c_in.idx   = k_ff[dob_pkg::IDX_W-1:0];
            c_in.size  = size_rd;
            c_in.value = $signed(value_rd);
         end
         dob_pkg::OP_MUL1:   prod1_in = mul_p;
         dob_pkg::OP_MUL2:   prod2_in = mul_p;
         dob_pkg::OP_POP: begin
            depth_in = depth_ff - CW'(1);
            b_in     = a_ff;
         end
         dob_pkg::OP_POP_LD: a_in = hull_pt;
         dob_pkg::OP_PUSH: begin
            a_in     = b_ff;
            b_in     = c_ff;
            depth_in = depth_ff + CW'(1);
            k_in     = k_ff + CW'(1);
         end
         dob_pkg::OP_EMIT_RD0: k_in = '0;
         dob_pkg::OP_EMIT_LD0: cur_in = hull_pt;
         dob_pkg::OP_NEXT_LD:  next_in = hull_pt;
         dob_pkg::OP_VMR: begin
            vmr_in = $signed({{(MW-VW-16){cur_ff.value[VW-1]}}, cur_ff.value, 16'b0})
                   - $signed({{(MW-RW){r_ff[RW-1]}}, r_ff});
            t1_in  = dob_pkg::SL_ABSENT;
            t2_in  = dob_pkg::SL_ABSENT;
         end
         dob_pkg::OP_TM1: tp_in  = mul_p;
         dob_pkg::OP_TM2: tql_in = mul_p;
         dob_pkg::OP_TM3: tqh_in = mul_p;
         dob_pkg::OP_TRES: begin
            if (cmd.side) t2_in = code;
            else          t1_in = code;
         end
         dob_pkg::OP_DEC: begin
            if (stat.qualify) begin
               if (pend_vld_ff) begin
                  out_in     = pend_ff;
                  out_fb_in  = 1'b0;
                  out_end_in = 1'b0;
                  out_vld_in = 1'b1;
               end
               pend_in     = cur_ff;
               pend_vld_in = 1'b1;
            end
         end
         dob_pkg::OP_SHIFT: begin
            prev_in = cur_ff;
            cur_in  = next_ff;
            k_in    = k_ff + CW'(1);
         end
         dob_pkg::OP_FIN: begin
            out_in      = pend_vld_ff ? pend_ff : cur_ff;
            out_fb_in   = !pend_vld_ff;
            out_end_in  = 1'b1;
            out_vld_in  = 1'b1;
            pend_vld_in = 1'b0;
            cnt_in      = '0;
            depth_in    = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         depth_ff    <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         eps_ff      <= dob_pkg::EPS_W'(1);
      end else begin
         cnt_ff      <= cnt_in;
         depth_ff    <= depth_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         eps_ff      <= eps_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      start_ff   <= start_in;
      minv_ff    <= minv_in;
      r_ff       <= r_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      prev_ff    <= prev_in;
      cur_ff     <= cur_in;
      next_ff    <= next_in;
      pend_ff    <= pend_in;
      prod1_ff   <= prod1_in;
      prod2_ff   <= prod2_in;
      tp_ff      <= tp_in;
      tql_ff     <= tql_in;
      tqh_ff     <= tqh_in;
      vmr_ff     <= vmr_in;
      t1_ff      <= t1_in;
      t2_ff      <= t2_in;
      out_ff     <= out_in;
      out_fb_ff  <= out_fb_in;
      out_end_ff <= out_end_in;
   end

   always_comb begin
      stat.k_last_pt  = (k_ff == cnt_ff - CW'(1));
      stat.j_last     = (k_ff == depth_ff - CW'(1));
      stat.have_prev  = (k_ff != '0);
      stat.depth_ge2  = (depth_ff >= CW'(2));
      stat.turn_right = (prod1_ff <= prod2_ff);
      if (t1_ff == dob_pkg::SL_INF || t2_ff == dob_pkg::SL_INF) begin
         stat.qualify = (cur_ff.size != '0);
      end else begin
         stat.qualify = (t1_ff == dob_pkg::SL_QUAL || t2_ff == dob_pkg::SL_QUAL);
      end
      stat.pend_vld   = pend_vld_ff;
      stat.slot_free  = slot_free;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_point_index = out_ff.idx;
   assign rsp_sel_size    = out_ff.size;
   assign rsp_sel_value   = out_ff.value;
   assign rsp_by_fallback = out_fb_ff;
   assign rsp_end_of_run  = out_end_ff;

endmodule

>>> hdl/direct_optimal_box_select_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel  | direction | handshake         | beat
// req_     | in        | req_valid/ready   | one box point, final_point closes the set
// rsp_     | out       | rsp_valid/ready   | one selected hull point, end_of_run on the last
// csr_     | in        | csr_wr_en         | eps_scale, written when idle
//
// a point beat that does not close the set is stored while room remains; the core stays idle
// the closing beat starts a pass: the least-value scan, then hull pushes and pops, then the
// slope tests for each hull point; hull and slope tests share the single 33x33 multiplier
// reset is synchronous; point stores and hull stack need no clearing
// req_ready drops for the pass; rsp stalls only hold the pass at a result hand-off

module direct_optimal_box_select_core #(
   parameter int MAX_POINTS = dob_pkg::MAX_POINTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [dob_pkg::SIZE_W-1:0]       req_box_size,
   input  logic signed [dob_pkg::VAL_W-1:0] req_box_value,
   input  logic signed [dob_pkg::VAL_W-1:0] req_best_value,
   input  logic                             req_final_point,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [dob_pkg::IDX_W-1:0]        rsp_point_index,
   output logic [dob_pkg::SIZE_W-1:0]       rsp_sel_size,
   output logic signed [dob_pkg::VAL_W-1:0] rsp_sel_value,
   output logic                             rsp_by_fallback,
   output logic                             rsp_end_of_run,
   input  logic                             csr_wr_en,
   input  logic [dob_pkg::EPS_W-1:0]        csr_wr_data
);

   // sequencer commands and datapath flags
   dob_pkg::cmd_type  cmd;
   dob_pkg::stat_type stat;

   // controller: scan, hull build and emit sequencing
   dob_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_final_point (req_final_point),
      .req_ready       (req_ready),
      .stat            (stat),
      .cmd             (cmd)
   );

   // datapath: stores, hull stack, shared multiplier, result register
   dob_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_box_size    (req_box_size),
      .req_box_value   (req_box_value),
      .req_best_value  (req_best_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_index (rsp_point_index),
      .rsp_sel_size    (rsp_sel_size),
      .rsp_sel_value   (rsp_sel_value),
      .rsp_by_fallback (rsp_by_fallback),
      .rsp_end_of_run  (rsp_end_of_run)
   );

   // closing a set always leaves the end-of-run beat on the output
   `DOB_ASSERT_NXT(a_fin_shows_end, clock, reset, cmd.op == dob_pkg::OP_FIN, rsp_valid && rsp_end_of_run, "fin without end beat")
   // no held result may remain while new points load
   `DOB_ASSERT_IMP(a_idle_no_pending, clock, reset, req_ready, !stat.pend_vld, "pending result at idle")
   // a hand-off of the held result only happens into a free slot
   `DOB_ASSERT_IMP(a_dec_slot, clock, reset, cmd.op == dob_pkg::OP_DEC && stat.qualify && stat.pend_vld, stat.slot_free, "result overwritten")

endmodule
